/* src/contiguous_slot_allocator_macros.svh */
// assertion macros for the slot allocator
`ifndef CONTIGUOUS_SLOT_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_SLOT_ALLOCATOR_MACROS_SVH

// same-cycle implication, off during reset
`define SCA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off during reset
`define SCA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/sca_pkg.sv */
// ----------------------------------------------------------------------------
// sca_pkg
// Types and codes shared by the contiguous slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package sca_pkg;

    // fit strategy register codes
    typedef enum logic [1:0] {
        STRAT_FIRST = 2'd0,
        STRAT_NEXT  = 2'd1,
        STRAT_BEST  = 2'd2,
        STRAT_WORST = 2'd3
    } strat_t;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_WRITE,
        ST_DONE
    } state_t;

    // request word
    typedef struct packed {
        logic [7:0] owner_id;
        logic [5:0] request_size;
    } req_t;

    // result word
    typedef struct packed {
        logic       granted;
        logic [4:0] start_slot;
        logic [7:0] granted_owner;
    } rsp_t;

endpackage

`default_nettype wire

/* src/sca_cell.sv */
// ----------------------------------------------------------------------------
// sca_cell
// One slot of the rotating slot ring: used flag and owner id.
// ----------------------------------------------------------------------------
`default_nettype none

module sca_cell #(
    parameter int OWNER_BITS = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  shift_en,
    input  wire logic [OWNER_BITS:0]   d,
    output logic      [OWNER_BITS:0]   q
);

    logic [OWNER_BITS:0] slot_reg;

    // take the neighbor's slot on each shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else if (shift_en)
        begin
            slot_reg <= d;
        end
    end

    assign q = slot_reg;

endmodule

`default_nettype wire

/* src/sca_ctrl.sv */
// ----------------------------------------------------------------------------
// sca_ctrl
// Scan and write sequencer: watches the ring head, picks the run, marks it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "contiguous_slot_allocator_macros.svh"

module sca_ctrl
    import sca_pkg::*;
#(
    parameter int SLOTS      = 32,
    parameter int OWNER_BITS = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire req_t                  req,
    output logic                       done,
    output rsp_t                       rsp,
    input  wire logic                  cfg_we,
    input  wire logic [1:0]            cfg_data,
    input  wire logic [OWNER_BITS:0]   head,
    output logic                       shift_en,
    output logic      [OWNER_BITS:0]   tail
);

    localparam int CW = $clog2(SLOTS + 1);

    state_t                state_reg, state_next;
    strat_t                strat_reg;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [CW-1:0]         len_reg, len_next;
    logic [OWNER_BITS-1:0] owner_reg, owner_next;
    logic [CW-1:0]         rover_reg, rover_next;
    logic [CW-1:0]         run_len_reg, run_len_next;
    logic [CW-1:0]         run_start_reg, run_start_next;
    logic                  ff_found_reg, ff_found_next;
    logic [CW-1:0]         ff_pos_reg, ff_pos_next;
    logic                  nf_found_reg, nf_found_next;
    logic [CW-1:0]         nf_pos_reg, nf_pos_next;
    logic                  hf_found_reg, hf_found_next;
    logic [CW-1:0]         hf_pos_reg, hf_pos_next;
    logic [CW-1:0]         hf_len_reg, hf_len_next;
    logic [CW-1:0]         pick_reg, pick_next;
    rsp_t                  rsp_reg, rsp_next;

    logic [CW-1:0]         rl1;
    logic [CW:0]           cand;
    logic [CW:0]           run_end;
    logic                  close_run;
    logic                  better;
    logic                  hf_found_c;
    logic [CW-1:0]         hf_pos_c;
    logic [CW-1:0]         hf_len_c;
    logic                  found_c;
    logic [CW-1:0]         pos_c;
    logic                  in_run;
    logic [OWNER_BITS-1:0] owner_in;

    assign owner_in = OWNER_BITS'(req.owner_id);

    // state and payload registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            strat_reg    <= STRAT_FIRST;
            rover_reg    <= '0;
            cnt_reg      <= '0;
            ff_found_reg <= 1'b0;
            nf_found_reg <= 1'b0;
            hf_found_reg <= 1'b0;
            run_len_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            rover_reg    <= rover_next;
            cnt_reg      <= cnt_next;
            ff_found_reg <= ff_found_next;
            nf_found_reg <= nf_found_next;
            hf_found_reg <= hf_found_next;
            run_len_reg  <= run_len_next;
            if (cfg_we)
            begin
                strat_reg <= strat_t'(cfg_data);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg       <= len_next;
        owner_reg     <= owner_next;
        run_start_reg <= run_start_next;
        ff_pos_reg    <= ff_pos_next;
        nf_pos_reg    <= nf_pos_next;
        hf_pos_reg    <= hf_pos_next;
        hf_len_reg    <= hf_len_next;
        pick_reg      <= pick_next;
        rsp_reg       <= rsp_next;
    end

    // run tracking and run closing
    always_comb
    begin
        rl1     = run_len_reg + CW'(1);
        cand    = {1'b0, cnt_reg} + (CW+1)'(1) - {1'b0, len_reg};
        run_end = {1'b0, pick_reg} + {1'b0, len_reg};
        in_run  = (cnt_reg >= pick_reg) && ({1'b0, cnt_reg} < run_end);

        close_run = (state_reg == ST_DECIDE) || (state_reg == ST_SCAN && head[OWNER_BITS]);
        if (strat_reg == STRAT_WORST)
        begin
            better = run_len_reg > hf_len_reg;
        end
        else
        begin
            better = run_len_reg < hf_len_reg;
        end
        hf_found_c = hf_found_reg;
        hf_pos_c   = hf_pos_reg;
        hf_len_c   = hf_len_reg;
        if (close_run && run_len_reg != '0 && run_len_reg >= len_reg
            && (!hf_found_reg || better))
        begin
            hf_found_c = 1'b1;
            hf_pos_c   = run_start_reg;
            hf_len_c   = run_len_reg;
        end

        unique case (strat_reg)
            STRAT_FIRST:
            begin
                found_c = ff_found_reg;
                pos_c   = ff_pos_reg;
            end
            STRAT_NEXT:
            begin
                found_c = ff_found_reg;
                pos_c   = nf_found_reg ? nf_pos_reg : ff_pos_reg;
            end
            default:
            begin
                found_c = hf_found_c;
                pos_c   = hf_pos_c;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        len_next       = len_reg;
        owner_next     = owner_reg;
        rover_next     = rover_reg;
        run_len_next   = run_len_reg;
        run_start_next = run_start_reg;
        ff_found_next  = ff_found_reg;
        ff_pos_next    = ff_pos_reg;
        nf_found_next  = nf_found_reg;
        nf_pos_next    = nf_pos_reg;
        hf_found_next  = hf_found_c;
        hf_pos_next    = hf_pos_c;
        hf_len_next    = hf_len_c;
        pick_next      = pick_reg;
        rsp_next       = rsp_reg;
        shift_en       = 1'b0;
        tail           = head;

        unique case (state_reg)
            ST_IDLE:
            begin
                hf_found_next = 1'b0;
                if (start)
                begin
                    owner_next    = owner_in;
                    cnt_next      = '0;
                    run_len_next  = '0;
                    ff_found_next = 1'b0;
                    nf_found_next = 1'b0;
                    hf_len_next   = '0;
                    if (req.request_size != '0 && int'(req.request_size) <= SLOTS)
                    begin
                        len_next   = CW'(req.request_size);
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        rsp_next.granted       = 1'b0;
                        rsp_next.start_slot    = '0;
                        rsp_next.granted_owner = 8'(owner_in);
                        state_next             = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                shift_en = 1'b1;
                cnt_next = cnt_reg + CW'(1);
                if (head[OWNER_BITS])
                begin
                    run_len_next = '0;
                end
                else
                begin
                    run_len_next = rl1;
                    if (run_len_reg == '0)
                    begin
                        run_start_next = cnt_reg;
                    end
                    if (rl1 >= len_reg)
                    begin
                        if (!ff_found_reg)
                        begin
                            ff_found_next = 1'b1;
                            ff_pos_next   = CW'(cand);
                        end
                        if (!nf_found_reg && CW'(cand) >= rover_reg)
                        begin
                            nf_found_next = 1'b1;
                            nf_pos_next   = CW'(cand);
                        end
                    end
                end
                if (int'(cnt_reg) == SLOTS - 1)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cnt_next  = '0;
                pick_next = pos_c;
                if (found_c)
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    rsp_next.granted       = 1'b0;
                    rsp_next.start_slot    = '0;
                    rsp_next.granted_owner = 8'(owner_reg);
                    state_next             = ST_DONE;
                end
            end
            ST_WRITE:
            begin
                shift_en = 1'b1;
                cnt_next = cnt_reg + CW'(1);
                if (in_run)
                begin
                    tail = {1'b1, owner_reg};
                end
                if (int'(cnt_reg) == SLOTS - 1)
                begin
                    if (strat_reg == STRAT_NEXT)
                    begin
                        rover_next = (int'(run_end) >= SLOTS) ? '0 : CW'(run_end);
                    end
                    rsp_next.granted       = 1'b1;
                    rsp_next.start_slot    = 5'(pick_reg);
                    rsp_next.granted_owner = 8'(owner_reg);
                    state_next             = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);
    assign rsp  = rsp_reg;

    // checks
    `SCA_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `SCA_ASSERT_NXT(a_done_single, clk, rst_n, done, !done)
    `SCA_ASSERT_IMP(a_no_shift_idle, clk, rst_n, !busy, !shift_en)
    `SCA_ASSERT_IMP(a_rover_range, clk, rst_n, 1'b1, int'(rover_reg) < SLOTS)

endmodule

`default_nettype wire

/* src/contiguous_slot_allocator.sv */
// ----------------------------------------------------------------------------
// contiguous_slot_allocator
// Allocates runs of contiguous free slots by first, next, best or worst fit.
// ----------------------------------------------------------------------------
// Usage:
//   A request word (owner_id, request_size) is taken when start is high and
//   busy is low. One result word (granted, start_slot, granted_owner) follows
//   on rsp with done high for exactly one cycle; the receiver cannot stall.
//   The slot map is a ring of SLOTS cells that rotates one slot per cycle
//   past a single sequencer while it scans or writes. The steps of a request:
//     accepted request:  scan trip, decide step, write trip, then done
//     refused size:      done straight after accept, with no scan
//     no fitting run:    scan trip and decide step, then done
//   busy stays high until the cycle after done, so one request is in work at
//   a time. The strategy register is written through cfg_we/cfg_data; the user
//   must write it only while idle, as the block itself does not enforce this.
//   Reset clears every slot to free, the rover to 0 and the strategy to
//   first fit, all at once.
// ----------------------------------------------------------------------------
`default_nettype none

module contiguous_slot_allocator
    import sca_pkg::*;
#(
    parameter int SLOTS      = 32,
    parameter int OWNER_BITS = 8
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire req_t       req,
    output logic            done,
    output rsp_t            rsp,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_data
);

    logic [OWNER_BITS:0] ring [SLOTS];
    logic [OWNER_BITS:0] tail;
    logic                shift_en;

    // sequencer
    sca_ctrl #(
        .SLOTS      (SLOTS),
        .OWNER_BITS (OWNER_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .done     (done),
        .rsp      (rsp),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .head     (ring[0]),
        .shift_en (shift_en),
        .tail     (tail)
    );

    // ring of slot cells, slot at cell 0 is the head
    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        if (g == SLOTS - 1)
        begin : g_last
            sca_cell #(.OWNER_BITS(OWNER_BITS)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (shift_en),
                .d        (tail),
                .q        (ring[g])
            );
        end
        else
        begin : g_mid
            sca_cell #(.OWNER_BITS(OWNER_BITS)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (shift_en),
                .d        (ring[g+1]),
                .q        (ring[g])
            );
        end
    end

endmodule

`default_nettype wire

/* verif/contiguous_slot_allocator_tb.sv */
// ----------------------------------------------------------------------------
// contiguous_slot_allocator_tb
// Drives allocation requests under all four fit strategies and compares each
// result word with an in-bench model of the slot map, rover and strategy.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module contiguous_slot_allocator_tb;
    import sca_pkg::*;

    localparam int NSLOT = 32;

    logic   clk;
    logic   rst_n;
    logic   start;
    logic   busy;
    req_t   req;
    logic   done;
    rsp_t   rsp;
    logic   cfg_we;
    logic [1:0] cfg_data;

    contiguous_slot_allocator dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_data(cfg_data)
    );

    // model state
    bit         map_used [NSLOT];
    int unsigned rover_pos;
    strat_t     fit_mode;

    req_t   pending_reqs[$];
    rsp_t   expected_grants[$];
    int     fail_count;
    int     send_idle_pct;
    bit     hold_sender;
    int     rv;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // limit
    initial
    begin
        #400ms;
        $display("[contiguous_slot_allocator] ERROR");
        $finish;
    end

    function automatic bit span_free(int unsigned s, int unsigned len);
        for (int unsigned k = 0; k < len; k++)
        begin
            if (s + k >= NSLOT || map_used[s + k])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int unsigned lowest_span(int unsigned lo, int unsigned len);
        for (int unsigned s = lo; s + len <= NSLOT; s++)
        begin
            if (span_free(s, len))
                return s;
        end
        return NSLOT;
    endfunction

    function automatic int unsigned hole_pick(int unsigned len, bit want_large);
        int unsigned pick, pick_len, run_s, run_l;
        pick = NSLOT;
        pick_len = 0;
        run_s = 0;
        run_l = 0;
        for (int unsigned i = 0; i <= NSLOT; i++)
        begin
            if (i < NSLOT && !map_used[i])
            begin
                if (run_l == 0)
                    run_s = i;
                run_l++;
            end
            else
            begin
                if (run_l >= len && run_l > 0 && (pick == NSLOT ||
                    (want_large ? run_l > pick_len : run_l < pick_len)))
                begin
                    pick = run_s;
                    pick_len = run_l;
                end
                run_l = 0;
            end
        end
        return pick;
    endfunction

    // allocation predictor: updates the map and returns the result word
    function automatic rsp_t allocate(req_t r);
        rsp_t        w;
        int unsigned len, s;
        len = r.request_size;
        s = NSLOT;
        if (len >= 1 && len <= NSLOT)
        begin
            case (fit_mode)
                STRAT_FIRST: s = lowest_span(0, len);
                STRAT_NEXT:
                begin
                    s = lowest_span(rover_pos < NSLOT ? rover_pos : 0, len);
                    if (s == NSLOT)
                        s = lowest_span(0, len);
                end
                STRAT_BEST:  s = hole_pick(len, 1'b0);
                default:     s = hole_pick(len, 1'b1);
            endcase
        end
        w.granted_owner = r.owner_id;
        if (s < NSLOT)
        begin
            for (int unsigned k = 0; k < len; k++)
                map_used[s + k] = 1'b1;
            if (fit_mode == STRAT_NEXT)
                rover_pos = (s + len >= NSLOT) ? 0 : s + len;
            w.granted = 1'b1;
            w.start_slot = s[4:0];
        end
        else
        begin
            w.granted = 1'b0;
            w.start_slot = '0;
        end
        return w;
    endfunction

    // driver: one word per handshake
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            req <= '0;
        end
        else
        begin
            if (start && !busy)
                expected_grants.insert(expected_grants.size(), allocate(req));
            if (start && busy)
                ;
            else if (pending_reqs.size() > 0 && !hold_sender &&
                     $urandom_range(99) >= send_idle_pct)
            begin
                start <= 1'b1;
                req <= pending_reqs.pop_front();
            end
            else
                start <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_grants.size() == 0)
            begin
                $error("result word with nothing expected");
                fail_count++;
            end
            else
            begin
                rsp_t e;
                e = expected_grants.pop_front();
                if (rsp.granted !== e.granted)
                begin
                    $error("granted exp %0d got %0d", e.granted, rsp.granted);
                    fail_count++;
                end
                if (rsp.start_slot !== e.start_slot)
                begin
                    $error("start_slot exp %0d got %0d", e.start_slot, rsp.start_slot);
                    fail_count++;
                end
                if (rsp.granted_owner !== e.granted_owner)
                begin
                    $error("granted_owner exp %0d got %0d", e.granted_owner,
                           rsp.granted_owner);
                    fail_count++;
                end
            end
        end
    end

    task automatic queue_req(int unsigned owner, int unsigned size);
        req_t r;
        r.owner_id = owner[7:0];
        r.request_size = size[5:0];
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    // wait until every queued word is taken and answered
    task automatic drain();
        while (pending_reqs.size() > 0 || start || expected_grants.size() > 0 || busy)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic set_mode(strat_t m);
        cfg_we <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        fit_mode = m;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // random batch: n requests of mixed sizes, with some zero and oversize ones;
    // slots are never released and a fresh map needs reset, so sizes are mixed
    task automatic random_batch(int n);
        int unsigned sz;
        for (int i = 0; i < n; i++)
        begin
            rv = $urandom_range(99);
            if (rv < 8)
                sz = $urandom_range(63, 33);
            else if (rv < 14)
                sz = 0;
            else if (rv < 60)
                sz = $urandom_range(4, 1);
            else
                sz = $urandom_range(32, 1);
            queue_req($urandom_range(255), sz);
        end
    endtask

    initial
    begin
        strat_t modes [4];
        modes = '{STRAT_FIRST, STRAT_NEXT, STRAT_BEST, STRAT_WORST};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        fail_count = 0;
        send_idle_pct = 12;
        hold_sender = 1'b0;
        rover_pos = 0;
        fit_mode = STRAT_FIRST;
        foreach (map_used[i])
            map_used[i] = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero, oversize and runs of different sizes, then the other strategies
        queue_req(8'hff, 0);
        queue_req(8'h00, 63);
        queue_req(8'h01, 33);
        queue_req(8'h11, 3);
        queue_req(8'h22, 1);
        queue_req(8'h33, 5);
        queue_req(8'h44, 2);
        queue_req(8'h55, 4);
        drain();
        set_mode(STRAT_BEST);
        queue_req(8'haa, 1);
        queue_req(8'hab, 2);
        drain();
        set_mode(STRAT_WORST);
        queue_req(8'h5a, 1);
        queue_req(8'ha5, 1);
        drain();
        set_mode(STRAT_NEXT);
        queue_req(8'h12, 2);
        queue_req(8'h34, 32);
        queue_req(8'h56, 6);
        queue_req(8'h78, 1);
        // sender is held while a word waits in the queue
        drain();
        hold_sender = 1'b1;
        queue_req(8'h9c, 20);
        repeat (3) @(posedge clk);
        hold_sender = 1'b0;
        drain();

        // random: the map only fills, so most items get refused after a while;
        // sizes lean small so that grants keep happening while free slots remain
        for (int ph = 0; ph < 24; ph++)
        begin
            send_idle_pct = (ph < 8) ? 12 : (ph < 16) ? 60 : 0;
            set_mode(modes[$urandom_range(3)]);
            random_batch(70);
            drain();
        end
        drain();
        if (fail_count == 0)
            $display("[contiguous_slot_allocator] OK");
        else
            $display("[contiguous_slot_allocator] ERROR");
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/sca_pkg.sv
src/sca_cell.sv
src/sca_ctrl.sv
src/contiguous_slot_allocator.sv
verif/contiguous_slot_allocator_tb.sv
